>>> hw/rtl/ffdl_pkg.sv
// Shared types and constants for the fractional feedback delay line.
`timescale 1ns / 1ps

package ffdl_pkg;

    localparam int SMP_W  = 24;   // Q1.23 audio sample
    localparam int DLY_W  = 20;   // delay, 12 integer and 8 fraction bits
    localparam int FRAC_W = 8;
    localparam int INT_W  = DLY_W - FRAC_W;
    localparam int GAIN_W = 16;   // Q1.15 feedback gain

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_FEEDBACK,
        ST_STORE
    } t_state;

endpackage

>>> hw/rtl/ffdl_hist_mem.sv
// Sample history memory: two registered read ports, one write port.
`timescale 1ns / 1ps

module ffdl_hist_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr_a,
    input  logic [AW-1:0]              i_rd_addr_b,
    output logic [ffdl_pkg::SMP_W-1:0] o_rd_data_a,
    output logic [ffdl_pkg::SMP_W-1:0] o_rd_data_b,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [ffdl_pkg::SMP_W-1:0] i_wr_data
);

    logic [ffdl_pkg::SMP_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= mem[i_rd_addr_a];
            o_rd_data_b <= mem[i_rd_addr_b];
        end
    end

endmodule

>>> hw/rtl/fractional_feedback_delay_line.sv
// Top level of the fractional feedback delay line with linear interpolation.
`timescale 1ns / 1ps

// Fractional feedback delay line. Each request carries a Q1.23 sample and a
// delay in samples with 8 fraction bits; the block reads the history entries
// (int + 1) and (int + 2) behind the write pointer, interpolates between them
// by the fraction (rounding half up) and returns that as sample_out. It then
// stores sample_in + sample_out * feedback_gain (Q1.15, rounded half up,
// saturated to 24 bits) at the write pointer and advances the pointer,
// wrapping at HISTORY_DEPTH. Delays beyond (HISTORY_DEPTH - 2) + 255/256 are
// clamped to that value. A sample passes through memory read, interpolation
// multiply, feedback multiply and write-back; the sequencer around the single
// history memory takes no new sample before that write-back, and it stalls
// only while a previous result still waits in the output register at the
// feedback step. The history reads as zero after reset with no clearing pass:
// a fill mark tracks which entries have been written since reset. The
// feedback gain is written through i_cfg_wr_en / i_cfg_wr_data and must
// only change while the block is idle.

module fractional_feedback_delay_line #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic signed [ffdl_pkg::GAIN_W-1:0]  i_cfg_wr_data,
    // input requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ffdl_pkg::SMP_W-1:0]   i_sample_in,
    input  logic        [ffdl_pkg::DLY_W-1:0]   i_delay_amount,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ffdl_pkg::SMP_W-1:0]   o_sample_out
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    // wide enough for pointer + depth - integer delay
    localparam int CW = ((AW > ffdl_pkg::INT_W) ? AW : ffdl_pkg::INT_W) + 2;
    localparam logic [31:0] DMAX = 32'((HISTORY_DEPTH - 2) * 256 + 255);
    localparam int SW = ffdl_pkg::SMP_W;

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    ffdl_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_wr_idx, n_wr_idx;
    logic             r_full, n_full;      // history has wrapped at least once
    logic             r_out_valid, n_out_valid;
    logic signed [ffdl_pkg::GAIN_W-1:0] r_gain;

    // Payload registers
    logic signed [SW-1:0]              r_x;
    logic [ffdl_pkg::FRAC_W-1:0]       r_frac;
    logic                              r_va, r_vb;   // taps hold written data
    logic signed [SW-1:0]              r_y;
    logic signed [SW+ffdl_pkg::GAIN_W-1:0] r_fb_prod;
    logic signed [SW-1:0]              r_out;

    // ---------------------------------------------------------------------
    // Address generation at request acceptance
    // ---------------------------------------------------------------------
    logic                         w_accept;
    logic [ffdl_pkg::DLY_W-1:0]   w_delay;
    logic [ffdl_pkg::INT_W-1:0]   w_dint;
    logic [CW-1:0]                w_p1_raw;
    logic [AW-1:0]                w_p1, w_p2;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        // clamp the delay to the longest one the history can serve
        if ({12'd0, i_delay_amount} > DMAX) begin
            w_delay = DMAX[ffdl_pkg::DLY_W-1:0];
        end else begin
            w_delay = i_delay_amount;
        end
        w_dint = w_delay[ffdl_pkg::DLY_W-1:ffdl_pkg::FRAC_W];

        w_p1_raw = CW'(r_wr_idx) + CW'(HISTORY_DEPTH) - CW'(w_dint) - CW'(1);
        if (w_p1_raw >= CW'(HISTORY_DEPTH)) begin
            w_p1_raw = w_p1_raw - CW'(HISTORY_DEPTH);
        end
        w_p1 = w_p1_raw[AW-1:0];
        w_p2 = (w_p1 == '0) ? AW'(HISTORY_DEPTH - 1) : w_p1 - AW'(1);
    end

    // ---------------------------------------------------------------------
    // History memory
    // ---------------------------------------------------------------------
    logic [SW-1:0] w_rd_a, w_rd_b;
    logic          w_wr_en;
    logic [SW-1:0] w_wr_data;

    ffdl_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (w_p1),
        .i_rd_addr_b (w_p2),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (r_wr_idx),
        .i_wr_data   (w_wr_data)
    );

    // ---------------------------------------------------------------------
    // Interpolation: y = floor((a*256 + f*(b - a) + 128) / 256)
    // ---------------------------------------------------------------------
    logic signed [SW-1:0]   w_a, w_b;
    logic signed [SW:0]     w_diff;
    logic signed [ffdl_pkg::FRAC_W:0] w_frac_s;
    logic signed [SW+9:0]   w_interp_prod;
    logic signed [SW+9:0]   w_acc;

    always_comb begin
        // an entry not yet written since reset reads as zero
        w_a           = r_va ? $signed(w_rd_a) : '0;
        w_b           = r_vb ? $signed(w_rd_b) : '0;
        w_diff        = {w_b[SW-1], w_b} - {w_a[SW-1], w_a};
        w_frac_s      = $signed({1'b0, r_frac});
        w_interp_prod = w_frac_s * w_diff;
        w_acc         = {{2{w_a[SW-1]}}, w_a, 8'd0} + w_interp_prod
                        + (SW+10)'(128);
    end

    // ---------------------------------------------------------------------
    // Feedback: fb = floor((y*g + 16384) / 32768), stored = sat(x + fb)
    // ---------------------------------------------------------------------
    logic signed [SW+ffdl_pkg::GAIN_W-1:0] w_fb_round;
    logic signed [SW:0]                    w_fb;
    logic signed [SW+1:0]                  w_sum;

    always_comb begin
        w_fb_round = r_fb_prod + (SW+ffdl_pkg::GAIN_W)'(16384);
        w_fb       = w_fb_round[SW+ffdl_pkg::GAIN_W-1:15];
        w_sum      = {{2{r_x[SW-1]}}, r_x} + {w_fb[SW], w_fb};
        // saturate when the top three bits disagree
        if (w_sum[SW+1:SW-1] == 3'b000 || w_sum[SW+1:SW-1] == 3'b111) begin
            w_wr_data = w_sum[SW-1:0];
        end else if (w_sum[SW+1]) begin
            w_wr_data = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_wr_data = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state and control outputs
    // ---------------------------------------------------------------------
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        w_wr_en     = 1'b0;

        // drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ffdl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ffdl_pkg::ST_INTERP;
                end
            end
            ffdl_pkg::ST_INTERP: begin
                n_state = ffdl_pkg::ST_FEEDBACK;
            end
            ffdl_pkg::ST_FEEDBACK: begin
                // hold here while the previous result still waits
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ffdl_pkg::ST_STORE;
                end
            end
            ffdl_pkg::ST_STORE: begin
                w_wr_en = 1'b1;
                if (r_wr_idx == AW'(HISTORY_DEPTH - 1)) begin
                    n_wr_idx = '0;
                    n_full   = 1'b1;
                end else begin
                    n_wr_idx = r_wr_idx + AW'(1);
                end
                n_state = ffdl_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffdl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffdl_pkg::ST_IDLE;
            r_wr_idx    <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gain      <= '0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_sample_in;
            r_frac <= w_delay[ffdl_pkg::FRAC_W-1:0];
            // the second tap may sit on the entry about to be written:
            // it still holds the old value, which is what is wanted
            r_va   <= r_full || (w_p1 < r_wr_idx);
            r_vb   <= r_full || (w_p2 < r_wr_idx);
        end
        if (r_state == ffdl_pkg::ST_INTERP) begin
            r_y <= w_acc[SW+7:8];
        end
        if (r_state == ffdl_pkg::ST_FEEDBACK && w_out_free) begin
            r_fb_prod <= r_y * r_gain;
            r_out     <= r_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

>>> verif/ffdl_scoreboard_pkg.sv
// Scoreboard class: predicts the delay line output and checks the results.
`timescale 1ns / 1ps

package ffdl_scoreboard_pkg;

    import ffdl_pkg::*;

    localparam int HIST_DEPTH = 4096;
    localparam int DLY_MAX    = (HIST_DEPTH - 2) * 256 + 255;
    localparam longint SAMPLE_MAX = 64'sd8388607;
    localparam longint SAMPLE_MIN = -64'sd8388608;

    class delay_line_scoreboard;

        logic signed [SMP_W-1:0]  history [HIST_DEPTH];
        int unsigned              wr_ptr;
        logic signed [GAIN_W-1:0] gain;
        logic signed [SMP_W-1:0]  expected_out [$];
        int n_requests, n_results, n_mismatch, n_wraps, n_clamped, n_gains;

        function new();
            foreach (history[i]) history[i] = '0;
            wr_ptr     = 0;
            gain       = '0;
            n_requests = 0;
            n_results  = 0;
            n_mismatch = 0;
            n_wraps    = 0;
            n_clamped  = 0;
            n_gains    = 0;
        endfunction

        function void set_gain(logic signed [GAIN_W-1:0] g);
            gain = g;
            n_gains++;
        endfunction

        // Interpolate the two taps behind the pointer, then write back
        // sample + output * gain, saturated, and advance the pointer.
        function void note_request(logic signed [SMP_W-1:0] smp, logic [DLY_W-1:0] dly);
            int unsigned d, whole, frac, tap_a, tap_b;
            longint a, b, acc, y, fb, sum;
            d = dly;
            if (d > DLY_MAX) begin
                d = DLY_MAX;
                n_clamped++;
            end
            whole = d >> FRAC_W;
            frac  = d & 32'hFF;
            tap_a = (wr_ptr + HIST_DEPTH - whole - 1) % HIST_DEPTH;
            tap_b = (tap_a == 0) ? HIST_DEPTH - 1 : tap_a - 1;
            a   = history[tap_a];
            b   = history[tap_b];
            acc = a * 256 + longint'(frac) * (b - a) + 128;
            y   = acc >>> 8;
            fb  = (y * longint'(gain) + 16384) >>> 15;
            sum = longint'(smp) + fb;
            if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
            if (sum < SAMPLE_MIN) sum = SAMPLE_MIN;
            history[wr_ptr] = sum[SMP_W-1:0];
            wr_ptr++;
            if (wr_ptr == HIST_DEPTH) begin
                wr_ptr = 0;
                n_wraps++;
            end
            expected_out.push_back(y[SMP_W-1:0]);
            n_requests++;
        endfunction

        function void report(string what, longint want, longint got);
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("ERROR %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_result(logic signed [SMP_W-1:0] got);
            logic signed [SMP_W-1:0] want;
            n_results++;
            if (expected_out.size() == 0) begin
                report("result with no request outstanding", 0, got);
                return;
            end
            want = expected_out.pop_front();
            if (got !== want)
                report("sample_out", want, got);
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void flush_check();
            if (expected_out.size() != 0)
                report("results never delivered", expected_out.size(), 0);
        endfunction

    endclass

endpackage

>>> verif/fractional_feedback_delay_line_tb.sv
// Testbench top for the fractional feedback delay line.
`timescale 1ns / 1ps

module fractional_feedback_delay_line_tb;

    import ffdl_pkg::*;
    import ffdl_scoreboard_pkg::*;

    // Random requests spread over the gain phases; together with the directed
    // part this keeps the run near eleven hundred and fifty requests.
    localparam int RAND_ITEMS    = 1128;
    localparam int N_PHASES      = 6;
    localparam int SETTLE_CYCLES = 8;     // lets the last write-back finish after the final result is taken
    localparam int LONG_HOLD     = 300;   // receiver hold-off, long enough to fill the block
    localparam int IDLE_LIMIT    = 2000;  // cycles without any handshake before giving up

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_wr_en    = 1'b0;
    logic signed [GAIN_W-1:0] i_cfg_wr_data  = '0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_ready;
    logic signed [SMP_W-1:0]  i_sample_in    = '0;
    logic        [DLY_W-1:0]  i_delay_amount = '0;
    logic                     o_out_valid;
    logic                     i_out_ready    = 1'b0;
    logic signed [SMP_W-1:0]  o_sample_out;

    // Idling switches and the long hold-off request, set by the stimulus process.
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    int rx_hold_asks = 0;

    delay_line_scoreboard sb = new();

    fractional_feedback_delay_line #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_delay_amount (i_delay_amount),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until it is taken. Valid stays high on
    // return; the caller lowers it only when a gap follows.
    task automatic send_request(input logic signed [SMP_W-1:0] smp,
                                input logic [DLY_W-1:0] dly);
        i_in_valid     <= 1'b1;
        i_sample_in    <= smp;
        i_delay_amount <= dly;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(smp, dly);
    endtask

    // Drop valid and wait until every outstanding result is back, then give
    // the block time to finish its write-back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the feedback gain; only ever called with the block idle.
    task automatic write_gain(input logic signed [GAIN_W-1:0] g);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_gain(g);
    endtask

    // Receiver: check each result as it is taken, then decide ready for the
    // next cycle. A long hold-off, when asked for, is counted down here.
    initial begin
        int run, hold_left, hold_seen;
        run       = 0;
        hold_left = 0;
        hold_seen = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_sample_out);
            if (rx_hold_asks != hold_seen) begin
                hold_seen = rx_hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!rx_idle_en) begin
                i_out_ready <= 1'b1;
            end else if (run > 0) begin
                run--;
            end else begin
                run = gap_len();
                if (run == 0) begin
                    i_out_ready <= 1'b1;
                    run = $urandom_range(0, 6);
                end else begin
                    i_out_ready <= 1'b0;
                    run = run - 1;
                end
            end
        end
    end

    // Watchdog: give up when no request and no result moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("fractional_feedback_delay_line: mismatch");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int                      sel, gap, per_phase, t;
        logic signed [SMP_W-1:0] smp;
        logic        [DLY_W-1:0] dly;
        logic signed [GAIN_W-1:0] phase_gain [N_PHASES];

        // Hold reset at the start, once.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, gain one half. Fresh history reads as zero.
        write_gain(16'sd16384);
        send_request(24'sh7FFFFF, 20'h00000);   // full scale in, reads untouched zeros
        send_request(24'sh800000, 20'h00000);   // newest tap is full scale, fed back
        send_request(24'sh123456, 20'h00080);   // half fraction, rounds half up
        send_request(24'shEDCBA9, 20'h000FF);   // top fraction
        send_request(24'sh000001, 20'h00001);   // bottom fraction
        send_request(24'sh400000, 20'h00100);   // integer one, no fraction
        send_request(24'shC00000, 20'h00180);
        send_request(24'sh7FFFFF, 20'hFFFFF);   // far too long: clamp to greatest delay
        send_request(24'sh800000, DLY_MAX[DLY_W-1:0]);   // greatest delay: old entry at pointer
        send_request(24'sh000000, DLY_MAX[DLY_W-1:0] + 20'd1);  // one step past greatest
        send_request(24'shFFFFFF, 20'h0017F);
        send_request(24'sh000000, 20'h00000);
        drain();

        // Most negative gain: feedback inverts the output.
        write_gain(-16'sd32768);
        send_request(24'sh7FFFFF, 20'h00000);
        send_request(24'sh800000, 20'h00000);   // min minus a positive output: saturate
        send_request(24'sh7FFFFF, 20'h000FF);
        send_request(24'sh800000, 20'h00080);
        drain();

        // Largest positive gain: drive the write-back into both saturation rails.
        write_gain(16'sd32767);
        send_request(24'sh7FFFFF, 20'h00000);
        send_request(24'sh7FFFFF, 20'h00000);
        send_request(24'sh800000, 20'h00000);
        send_request(24'sh800000, 20'h00000);
        drain();

        // Random part in phases, one gain per phase, extremes among them.
        phase_gain[0] = 16'sh7FFF;
        phase_gain[1] = 16'sh8000;
        phase_gain[2] = 16'sh0000;
        phase_gain[3] = 16'($urandom_range(0, 65535));
        phase_gain[4] = 16'shFFFF;
        phase_gain[5] = 16'sh0001;
        per_phase = RAND_ITEMS / N_PHASES;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_gain(phase_gain[ph]);
            // One phase runs flat out on both sides.
            tx_idle_en = (ph != 3);
            rx_idle_en = (ph != 3);
            for (int k = 0; k < per_phase; k++) begin
                // Receiver goes quiet for a long stretch while requests keep coming.
                if (ph == 1 && k == 100)
                    rx_hold_asks++;
                // Sender pauses until every result is back, then carries on.
                if (ph == 2 && k == 100)
                    drain();

                sel = $urandom_range(0, 9);
                case (sel)
                    0: smp = 24'sh7FFFFF;
                    1: smp = 24'sh800000;
                    2, 3, 4: smp = 24'($urandom);
                    default: begin
                        t   = $urandom_range(0, 2097151) - 1048576;
                        smp = 24'(t);
                    end
                endcase

                // Mostly short delays onto recent history, with long ones,
                // near-greatest and clamped ones, and exact fraction points.
                sel = $urandom_range(0, 9);
                case (sel)
                    0, 1, 2, 3: dly = 20'($urandom_range(0, 16'h3FFF));
                    4, 5:       dly = 20'($urandom);
                    6:          dly = 20'($urandom_range(DLY_MAX - 255, 20'hFFFFF));
                    7: begin
                        dly = 20'($urandom_range(0, HIST_DEPTH - 2) << FRAC_W);
                        case ($urandom_range(0, 2))
                            0: dly[FRAC_W-1:0] = 8'h00;
                            1: dly[FRAC_W-1:0] = 8'h80;
                            default: dly[FRAC_W-1:0] = 8'hFF;
                        endcase
                    end
                    default: dly = 20'($urandom_range(0, 3 * 256 + 255));
                endcase

                send_request(smp, dly);
                gap = tx_idle_en ? gap_len() : 0;
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            drain();
        end

        sb.flush_check();
        $display("covered %0d requests and %0d results over %0d gain settings",
                 sb.n_requests, sb.n_results, sb.n_gains);
        $display("write pointer wrapped %0d times, %0d delays clamped, %0d errors",
                 sb.n_wraps, sb.n_clamped, sb.n_mismatch);
        if (sb.n_mismatch == 0)
            $display("fractional_feedback_delay_line: match");
        else
            $display("fractional_feedback_delay_line: mismatch");
        $finish;
    end

endmodule
